@@ rtl/fac_pkg.sv @@
package fac_pkg;

    localparam int REG_COUNT = 6;
    localparam int ADDR_W    = 6;
    localparam int DATA_W    = 64;
    localparam int PROD_W    = 32;
    localparam int SUM_W     = 34;

    typedef logic signed [15:0] coord_t;

    // Register layout: d in bits 63:48, nz 47:32, ny 31:16, nx 15:0
    typedef struct packed {
        coord_t       d;
        coord_t [2:0] n;
    } plane_t;

    typedef struct packed {
        coord_t [2:0] hi;
        coord_t [2:0] lo;
    } box_t;

    typedef struct packed {
        logic p_neg;
        logic n_neg;
    } plane_flags_t;

    typedef enum logic [1:0] {
        VERDICT_OUTSIDE   = 2'd0,
        VERDICT_INTERSECT = 2'd1,
        VERDICT_INSIDE    = 2'd2
    } verdict_t;

endpackage

@@ rtl/frustum_aabb_cull_unit.sv @@
// Frustum culling unit: classifies axis-aligned boxes against up to six planes.
// Planes are written over the APB port (64-bit words, register i at byte 8*i:
// left, right, bottom, top, near, far). Each packs nx, ny, nz (Q2.14) and d (Q12.4).
// Write planes only while no box is in flight.
// Input channel s_*: one box word per handshake, min and max corners in Q12.4.
// Output channel m_*: one verdict word per box, 0 outside, 1 intersect, 2 inside.
// From the input handshake to m_valid a box passes the box register, loaded on the
// handshake edge, then the corner select and multiply stage (one 16x16 multiplier per
// plane, axis and corner), the plane sum stage with its sign flag register, and the verdict register.
// Throughput is one box per cycle while the receiver does not stall the output.
// The whole pipeline advances together whenever the output register is empty
// or being taken; when the receiver stalls every stage holds and s_ready drops,
// so nothing is lost or repeated.
// Reset clears all valid bits and sets every plane to zero; an all-zero plane
// never rejects, so after reset every box reads inside.
module frustum_aabb_cull_unit #(
    parameter int PLANE_COUNT = 6
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fac_pkg::ADDR_W-1:0]  paddr,
    input  logic [fac_pkg::DATA_W-1:0]  pwdata,
    output logic [fac_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [15:0]          s_min_x,
    input  logic signed [15:0]          s_min_y,
    input  logic signed [15:0]          s_min_z,
    input  logic signed [15:0]          s_max_x,
    input  logic signed [15:0]          s_max_y,
    input  logic signed [15:0]          s_max_z,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_verdict
);
    import fac_pkg::*;

    plane_t           planes [REG_COUNT];
    plane_t           plane_sel [PLANE_COUNT];
    plane_flags_t     flags [PLANE_COUNT];
    logic             advance;
    logic             v1_reg;
    logic             v2_reg;
    logic             v3_reg;
    logic             m_valid_reg;
    box_t             box_reg;
    verdict_t         verdict_reg;
    verdict_t         verdict_next;
    logic [PLANE_COUNT-1:0] p_neg;
    logic [PLANE_COUNT-1:0] n_neg;

    fac_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .planes  (planes)
    );

    // advance the whole pipe unless the output word is held by the receiver
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            m_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            box_reg.lo[0] <= s_min_x;
            box_reg.lo[1] <= s_min_y;
            box_reg.lo[2] <= s_min_z;
            box_reg.hi[0] <= s_max_x;
            box_reg.hi[1] <= s_max_y;
            box_reg.hi[2] <= s_max_z;
            verdict_reg   <= verdict_next;
        end
    end

    for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_plane
        if (k < REG_COUNT) begin : g_reg
            assign plane_sel[k] = planes[k];
        end else begin : g_zero
            assign plane_sel[k] = '0;
        end

        fac_plane_eval u_eval (
            .aclk    (aclk),
            .advance (advance),
            .plane   (plane_sel[k]),
            .box     (box_reg),
            .flags   (flags[k])
        );

        assign p_neg[k] = flags[k].p_neg;
        assign n_neg[k] = flags[k].n_neg;
    end

    always_comb begin
        if (|p_neg) begin
            verdict_next = VERDICT_OUTSIDE;
        end else if (|n_neg) begin
            verdict_next = VERDICT_INTERSECT;
        end else begin
            verdict_next = VERDICT_INSIDE;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_verdict = verdict_reg;

endmodule

@@ rtl/fac_regs.sv @@
module fac_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fac_pkg::ADDR_W-1:0]  paddr,
    input  logic [fac_pkg::DATA_W-1:0]  pwdata,
    output logic [fac_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output fac_pkg::plane_t             planes [fac_pkg::REG_COUNT]
);
    import fac_pkg::*;

    logic [2:0] reg_index;
    logic       wr_en;
    plane_t     planes_reg [REG_COUNT];

    assign reg_index = paddr[ADDR_W-1:3];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                planes_reg[i] <= '0;
            end
        end else if (wr_en) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                if (reg_index == 3'(i)) begin
                    planes_reg[i] <= plane_t'(pwdata);
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        for (int i = 0; i < REG_COUNT; i++) begin
            if (reg_index == 3'(i)) begin
                prdata = DATA_W'(planes_reg[i]);
            end
        end
    end

    assign planes = planes_reg;

endmodule

@@ rtl/fac_plane_eval.sv @@
module fac_plane_eval (
    input  logic                  aclk,
    input  logic                  advance,
    input  fac_pkg::plane_t       plane,
    input  fac_pkg::box_t         box,
    output fac_pkg::plane_flags_t flags
);
    import fac_pkg::*;

    coord_t                    pv [3];
    coord_t                    nv [3];
    logic signed [PROD_W-1:0]  prod_p_reg [3];
    logic signed [PROD_W-1:0]  prod_n_reg [3];
    logic signed [SUM_W-1:0]   d_term;
    logic signed [SUM_W-1:0]   sum_p;
    logic signed [SUM_W-1:0]   sum_n;
    plane_flags_t              flags_reg;

    // pick the far (p) and near (n) corner one axis at a time
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            pv[a] = ($signed(plane.n[a]) > 0) ? box.hi[a] : box.lo[a];
            nv[a] = ($signed(plane.n[a]) < 0) ? box.hi[a] : box.lo[a];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int a = 0; a < 3; a++) begin
                prod_p_reg[a] <= $signed(plane.n[a]) * $signed(pv[a]);
                prod_n_reg[a] <= $signed(plane.n[a]) * $signed(nv[a]);
            end
        end
    end

    // d is Q12.4; scale by 2^14 to line up with the Q.18 products
    assign d_term = $signed({{(SUM_W-30){plane.d[15]}}, plane.d, 14'b0});

    always_comb begin
        sum_p = d_term;
        sum_n = d_term;
        for (int a = 0; a < 3; a++) begin
            sum_p = sum_p + SUM_W'(prod_p_reg[a]);
            sum_n = sum_n + SUM_W'(prod_n_reg[a]);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            flags_reg.p_neg <= sum_p[SUM_W-1];
            flags_reg.n_neg <= sum_n[SUM_W-1];
        end
    end

    assign flags = flags_reg;

endmodule
